FILE: sv/rdib_pkg.sv
// ----------------------------------------------------------------------------
// rdib_pkg
// Shared types, codes and tables of the run-length block decoder.
// ----------------------------------------------------------------------------
package rdib_pkg;

  localparam logic [1:0] MODE_COEF    = 2'd0;
  localparam logic [1:0] MODE_QUANT   = 2'd1;
  localparam logic [1:0] MODE_SCALE   = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [15:0] PAD_WORD = 16'hFE00;

  localparam logic [5:0] ZIGZAG [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        coefficient_word;
    logic [6:0]         table_address;
    logic signed [15:0] table_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [5:0]         position;
    logic [2:0]         block_number;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic dc_wait;
    logic pad;
    logic k_end;
  } status_t;

  typedef struct packed {
    logic       quant_we;
    logic       scale_we;
    logic       restart;
    logic       dc_start;
    logic       ac_start;
    logic       dc_mul;
    logic       ac_mul1;
    logic       ac_mul2;
    logic       dc_wr;
    logic       ac_wr;
    logic       id_rd;
    logic       id_mul;
    logic       id_acc;
    logic       acc_first;
    logic       id_wr;
    logic       pass;
    logic [5:0] src_addr;
    logic [5:0] scale_addr;
    logic [5:0] dst_addr;
    logic       em_rd;
    logic       em_ld;
    logic [5:0] em_addr;
    logic       block_done;
  } cmd_t;

endpackage

FILE: sv/rdib_ctrl.sv
// ----------------------------------------------------------------------------
// rdib_ctrl
// Sequencer: coefficient decode steps, idct multiply-accumulate loop, emit.
// ----------------------------------------------------------------------------
module rdib_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         in_mode_i,
  input  rdib_pkg::status_t  status_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output rdib_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DC_MUL  = 4'd1;
  localparam logic [3:0] S_DC_WR   = 4'd2;
  localparam logic [3:0] S_AC_MUL1 = 4'd3;
  localparam logic [3:0] S_AC_MUL2 = 4'd4;
  localparam logic [3:0] S_AC_WR   = 4'd5;
  localparam logic [3:0] S_ID_RD   = 4'd6;
  localparam logic [3:0] S_ID_MUL  = 4'd7;
  localparam logic [3:0] S_ID_ACC  = 4'd8;
  localparam logic [3:0] S_ID_WR   = 4'd9;
  localparam logic [3:0] S_EM_RD   = 4'd10;
  localparam logic [3:0] S_EM_LD   = 4'd11;
  localparam logic [3:0] S_EM_HOLD = 4'd12;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;
  logic [2:0] c_q, c_d, r_q, r_d, z_q, z_d;
  logic [5:0] e_q, e_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    c_d     = c_q;
    r_d     = r_q;
    z_d     = z_q;
    e_d     = e_q;
    cmd_o   = '0;
    cmd_o.pass       = pass_q;
    cmd_o.src_addr   = {z_q, r_q};
    cmd_o.scale_addr = {z_q, c_q};
    cmd_o.dst_addr   = {r_q, c_q};
    cmd_o.em_addr    = e_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            rdib_pkg::MODE_QUANT:   cmd_o.quant_we = 1'b1;
            rdib_pkg::MODE_SCALE:   cmd_o.scale_we = 1'b1;
            rdib_pkg::MODE_RESTART: cmd_o.restart  = 1'b1;
            default: begin
              if (status_i.dc_wait) begin
                if (!status_i.pad) begin
                  cmd_o.dc_start = 1'b1;
                  state_d = S_DC_MUL;
                end
              end else if (!status_i.k_end) begin
                cmd_o.ac_start = 1'b1;
                state_d = S_AC_MUL1;
              end else begin
                pass_d  = 1'b0;
                c_d     = '0;
                r_d     = '0;
                z_d     = '0;
                state_d = S_ID_RD;
              end
            end
          endcase
        end
      end
      S_DC_MUL: begin
        cmd_o.dc_mul = 1'b1;
        state_d = S_DC_WR;
      end
      S_DC_WR: begin
        cmd_o.dc_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_AC_MUL1: begin
        cmd_o.ac_mul1 = 1'b1;
        state_d = S_AC_MUL2;
      end
      S_AC_MUL2: begin
        cmd_o.ac_mul2 = 1'b1;
        state_d = S_AC_WR;
      end
      S_AC_WR: begin
        cmd_o.ac_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_ID_RD: begin
        cmd_o.id_rd = 1'b1;
        state_d = S_ID_MUL;
      end
      S_ID_MUL: begin
        cmd_o.id_mul = 1'b1;
        state_d = S_ID_ACC;
      end
      S_ID_ACC: begin
        cmd_o.id_acc    = 1'b1;
        cmd_o.acc_first = (z_q == 3'd0);
        if (z_q == 3'd7) begin
          z_d = '0;
          state_d = S_ID_WR;
        end else begin
          z_d = z_q + 3'd1;
          state_d = S_ID_RD;
        end
      end
      S_ID_WR: begin
        cmd_o.id_wr = 1'b1;
        state_d = S_ID_RD;
        if (r_q == 3'd7) begin
          r_d = '0;
          if (c_q == 3'd7) begin
            c_d = '0;
            if (pass_q) begin
              e_d = '0;
              state_d = S_EM_RD;
            end else begin
              pass_d = 1'b1;
            end
          end else begin
            c_d = c_q + 3'd1;
          end
        end else begin
          r_d = r_q + 3'd1;
        end
      end
      S_EM_RD: begin
        cmd_o.em_rd = 1'b1;
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        cmd_o.em_ld = 1'b1;
        state_d = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        if (!out_stall_i) begin
          if (e_q == 6'd63) begin
            cmd_o.block_done = 1'b1;
            state_d = S_IDLE;
          end else begin
            e_d = e_q + 6'd1;
            state_d = S_EM_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
      c_q     <= '0;
      r_q     <= '0;
      z_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      c_q     <= c_d;
      r_q     <= r_d;
      z_q     <= z_d;
      e_q     <= e_d;
    end
  end

endmodule

FILE: sv/rdib_datapath.sv
// ----------------------------------------------------------------------------
// rdib_datapath
// Tables, coefficient and pass memories, multipliers and output register.
// ----------------------------------------------------------------------------
module rdib_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rdib_pkg::in_beat_t  in_data_i,
  input  rdib_pkg::cmd_t      cmd_i,
  input  logic                out_stall_i,
  output rdib_pkg::status_t   status_o,
  output logic                out_valid_o,
  output rdib_pkg::out_beat_t out_data_o
);

  function automatic logic signed [10:0] clamp11(input logic signed [26:0] v);
    if (v > 27'sd1023) begin
      return 11'sd1023;
    end else if (v < -27'sd1024) begin
      return -11'sd1024;
    end
    return 11'(v);
  endfunction

  logic [7:0]         quant_mem [128];
  logic [15:0]        scale_mem [64];
  logic signed [10:0] coef_mem  [64];
  logic [15:0]        pass_mem  [64];
  logic [15:0]        samp_mem  [64];
  logic [63:0]        coef_vld_q;

  logic               dc_wait_q;
  logic [5:0]         pos_q;
  logic [5:0]         scale_q;
  logic [2:0]         blk_q;
  logic [15:0]        word_q;
  logic [5:0]         k_q;
  logic signed [10:0] dc2_q;
  logic [7:0]         qrd_q;
  logic signed [10:0] crd_q;
  logic               cvld_q;
  logic [15:0]        prd_q;
  logic signed [15:0] srd_q;
  logic [15:0]        erd_q;
  logic signed [18:0] p1_q;
  logic signed [25:0] p2_q;
  logic signed [28:0] prod_q;
  logic signed [31:0] acc_q;
  logic               out_valid_q;
  rdib_pkg::out_beat_t out_q;

  logic [6:0]         k_in;
  logic [6:0]         qaddr;
  logic signed [9:0]  val10;
  logic signed [8:0]  mulb;
  logic signed [26:0] ac_t;
  logic signed [26:0] ac_r;
  logic signed [10:0] ac_v;
  logic signed [15:0] src16;
  logic signed [15:0] sadj;
  logic signed [12:0] s8;
  logic signed [32:0] rnd_t;
  logic [15:0]        res16;

  assign k_in  = {1'b0, pos_q} + {1'b0, in_data_i.coefficient_word[15:10]} + 7'd1;
  assign qaddr = {(blk_q < 3'd2), (dc_wait_q ? 6'd0 : k_in[5:0])};

  assign status_o.dc_wait = dc_wait_q;
  assign status_o.pad     = (in_data_i.coefficient_word == rdib_pkg::PAD_WORD);
  assign status_o.k_end   = k_in[6];

  assign val10 = word_q[9:0];
  assign mulb  = (cmd_i.dc_mul && scale_q == 6'd0) ? 9'sd2 : $signed({1'b0, qrd_q});

  always_comb begin
    ac_t = 27'(p2_q) + 27'sd4;
    if (ac_t < 0) begin
      ac_t = ac_t + 27'sd7;
    end
    ac_r = ac_t >>> 3;
    ac_v = (scale_q != 6'd0) ? clamp11(ac_r) : dc2_q;
  end

  assign src16 = cmd_i.pass ? $signed(prd_q) : (cvld_q ? 16'(crd_q) : 16'sd0);
  assign sadj  = srd_q[15] ? (srd_q + 16'sd7) : srd_q;
  assign s8    = 13'(sadj >>> 3);

  always_comb begin
    rnd_t = 33'(acc_q) + 33'sd4095;
    if (rnd_t < 0) begin
      rnd_t = rnd_t + 33'sd8191;
    end
    res16 = 16'(rnd_t >>> 13);
  end

  // tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.quant_we) begin
      quant_mem[in_data_i.table_address] <= in_data_i.table_value[7:0];
    end
    qrd_q <= quant_mem[qaddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_we) begin
      scale_mem[in_data_i.table_address[5:0]] <= in_data_i.table_value;
    end
    if (cmd_i.id_rd) begin
      srd_q <= scale_mem[cmd_i.scale_addr];
    end
  end

  // coefficient memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.dc_wr) begin
      coef_mem[6'd0] <= clamp11(27'(p1_q));
    end else if (cmd_i.ac_wr) begin
      coef_mem[(scale_q != 6'd0) ? rdib_pkg::ZIGZAG[k_q] : k_q] <= ac_v;
    end
    if (cmd_i.id_rd) begin
      crd_q <= coef_mem[cmd_i.src_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      cvld_q     <= 1'b0;
    end else begin
      if (cmd_i.dc_start) begin
        coef_vld_q <= '0;
      end else if (cmd_i.dc_wr) begin
        coef_vld_q[6'd0] <= 1'b1;
      end else if (cmd_i.ac_wr) begin
        coef_vld_q[(scale_q != 6'd0) ? rdib_pkg::ZIGZAG[k_q] : k_q] <= 1'b1;
      end
      if (cmd_i.id_rd) begin
        cvld_q <= coef_vld_q[cmd_i.src_addr];
      end
    end
  end

  // pass and sample memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.id_wr && !cmd_i.pass) begin
      pass_mem[cmd_i.dst_addr] <= res16;
    end
    if (cmd_i.id_rd) begin
      prd_q <= pass_mem[cmd_i.src_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.id_wr && cmd_i.pass) begin
      samp_mem[cmd_i.dst_addr] <= res16;
    end
    if (cmd_i.em_rd) begin
      erd_q <= samp_mem[cmd_i.em_addr];
    end
  end

  // arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.dc_start || cmd_i.ac_start) begin
      word_q <= in_data_i.coefficient_word;
    end
    if (cmd_i.ac_start) begin
      k_q <= k_in[5:0];
    end
    if (cmd_i.dc_start) begin
      scale_q <= in_data_i.coefficient_word[15:10];
    end
    if (cmd_i.dc_mul || cmd_i.ac_mul1) begin
      p1_q <= val10 * mulb;
    end
    if (cmd_i.ac_mul2) begin
      p2_q <= p1_q * $signed({1'b0, scale_q});
    end
    if (cmd_i.dc_wr) begin
      dc2_q <= clamp11(27'(p1_q));
    end
    if (cmd_i.id_mul) begin
      prod_q <= src16 * s8;
    end
    if (cmd_i.id_acc) begin
      acc_q <= cmd_i.acc_first ? 32'(prod_q) : (acc_q + 32'(prod_q));
    end
    if (cmd_i.em_ld) begin
      out_q.sample       <= erd_q;
      out_q.position     <= cmd_i.em_addr;
      out_q.block_number <= blk_q;
      out_q.last         <= (cmd_i.em_addr == 6'd63);
    end
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_wait_q   <= 1'b1;
      pos_q       <= '0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.dc_start) begin
        dc_wait_q <= 1'b0;
        pos_q     <= '0;
      end else if (cmd_i.ac_wr) begin
        pos_q <= k_q;
      end else if (cmd_i.block_done) begin
        dc_wait_q <= 1'b1;
        pos_q     <= '0;
      end
      if (cmd_i.restart) begin
        blk_q <= '0;
      end else if (cmd_i.block_done) begin
        blk_q <= (blk_q >= 3'd5) ? 3'd0 : blk_q + 3'd1;
      end
      if (cmd_i.em_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/rle_dequant_idct_block_decoder.sv
// ----------------------------------------------------------------------------
// rle_dequant_idct_block_decoder
// Run-length 8x8 block decoder: dequantize, two-pass idct, raster emit.
// ----------------------------------------------------------------------------
// Table writes, restarts and padding are taken one per beat in idle; a DC
// word runs DC_MUL, DC_WR and an AC word AC_MUL1, AC_MUL2, AC_WR. The word
// that ends a block starts the idct: one shared multiply-accumulate unit
// reads, multiplies and accumulates each product in two passes of 64 results,
// then the 64 samples leave in raster order, each held until taken. No input
// beat is taken from the end of a block until its last sample is taken.
module rle_dequant_idct_block_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rdib_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdib_pkg::out_beat_t out_data_o
);

  rdib_pkg::cmd_t    cmd;
  rdib_pkg::status_t status;

  rdib_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .status_i    (status),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  rdib_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_input_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a sample is pending");

  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> !out_valid_o)
    else $error("sample after last of block");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> !in_stall_o)
    else $error("not ready after block emitted");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.position == 6'd63)))
    else $error("last flag and position disagree");
`endif

endmodule
